### design/imuma_pkg.sv
package imuma_pkg;

    // fixed field widths and channel count
    localparam int NUM_CH    = 10;
    localparam int DATA_W    = 32;
    localparam int TAG_W     = 32;
    localparam int CFG_W     = 7;
    localparam int WIN_RESET = 10;
    localparam int CH_W      = $clog2(NUM_CH);

    // channel order: quat x y z w, rate x y z, accel x y z
    localparam int CH_QUAT_X  = 0;
    localparam int CH_QUAT_Y  = 1;
    localparam int CH_QUAT_Z  = 2;
    localparam int CH_QUAT_W  = 3;
    localparam int CH_RATE_X  = 4;
    localparam int CH_RATE_Y  = 5;
    localparam int CH_RATE_Z  = 6;
    localparam int CH_ACCEL_X = 7;
    localparam int CH_ACCEL_Y = 8;
    localparam int CH_ACCEL_Z = 9;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [TAG_W-1:0]         tag_t;
    typedef logic [CFG_W-1:0]         win_t;
    typedef logic [CH_W-1:0]          ch_t;
    typedef data_t [NUM_CH-1:0]       row_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic update;
        logic div_load;
        logic div_step;
        logic div_store;
        logic out_load;
        ch_t  ch;
    } imuma_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic emit;
        logic full;
    } imuma_status_t;

endpackage

### design/imuma_if.sv
interface imuma_sample_if import imuma_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t quat_x;
    data_t quat_y;
    data_t quat_z;
    data_t quat_w;
    data_t rate_x;
    data_t rate_y;
    data_t rate_z;
    data_t accel_x;
    data_t accel_y;
    data_t accel_z;
    tag_t  sample_tag;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z,
               accel_x, accel_y, accel_z, sample_tag,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z,
               accel_x, accel_y, accel_z, sample_tag,
        output ready
    );
endinterface

interface imuma_mean_if import imuma_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t mean_quat_x;
    data_t mean_quat_y;
    data_t mean_quat_z;
    data_t mean_quat_w;
    data_t mean_rate_x;
    data_t mean_rate_y;
    data_t mean_rate_z;
    data_t mean_accel_x;
    data_t mean_accel_y;
    data_t mean_accel_z;
    tag_t  result_tag;

    modport source (
        output valid, mean_quat_x, mean_quat_y, mean_quat_z, mean_quat_w,
               mean_rate_x, mean_rate_y, mean_rate_z,
               mean_accel_x, mean_accel_y, mean_accel_z, result_tag,
        input  ready
    );
    modport sink (
        input  valid, mean_quat_x, mean_quat_y, mean_quat_z, mean_quat_w,
               mean_rate_x, mean_rate_y, mean_rate_z,
               mean_accel_x, mean_accel_y, mean_accel_z, result_tag,
        output ready
    );
endinterface

interface imuma_cfg_if import imuma_pkg::*; ();
    logic valid;
    logic ready;
    win_t avg_len;

    modport source (
        output valid, avg_len,
        input  ready
    );
    modport sink (
        input  valid, avg_len,
        output ready
    );
endinterface

### design/imuma_ctrl.sv
module imuma_ctrl import imuma_pkg::*; #(
    parameter int SUM_W = 38
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  imuma_status_t status,
    output imuma_cmd_t    cmd
);

    localparam int BIT_W = $clog2(SUM_W);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(SUM_W - 1);
    localparam ch_t CH_LAST = CH_W'(NUM_CH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_LOAD,
        S_STEP,
        S_STORE,
        S_PUSH
    } state_t;

    state_t           state_reg, state_next;
    ch_t              ch_reg, ch_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             out_valid_reg, out_valid_next;

    // sequencing: update, then, if the sample gives a result, one divide per channel, then hand off
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.ch         = ch_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                ch_next    = '0;
                state_next = status.emit ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                bit_next     = '0;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 1'b1;
                if (bit_reg == BIT_LAST)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.div_store = 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### design/imuma_dp.sv
module imuma_dp import imuma_pkg::*; #(
    parameter int WINDOW_MAX = 64,
    parameter int SUM_W      = 38
) (
    input  logic          clk,
    input  logic          rst_n,
    input  imuma_cmd_t    cmd,
    output imuma_status_t status,
    input  row_t          in_row,
    input  tag_t          in_tag,
    input  logic          cfg_valid,
    input  win_t          cfg_window,
    output row_t          mean_row,
    output tag_t          mean_tag
);

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam win_t WIN_INIT = CFG_W'((WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET);

    typedef logic signed [SUM_W-1:0] sum_t;

    win_t             win_reg;
    win_t             fill_reg;
    logic [PTR_W-1:0] pos_reg, pos_next;
    sum_t             sum_reg [NUM_CH];
    sum_t             sum_next [NUM_CH];

    row_t             ring_mem [WINDOW_MAX];
    row_t             old_reg;
    row_t             sample_reg;
    tag_t             tag_reg;

    logic [SUM_W-1:0] quo_reg;
    win_t             rem_reg;
    logic             neg_reg;
    row_t             stage_reg;
    row_t             mean_reg;
    tag_t             mean_tag_reg;

    sum_t             div_sum;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   trial_diff;
    logic             trial_ge;
    data_t            quo_low;

    // zero means one, anything above the ring depth saturates
    function automatic win_t clamp_window(win_t w);
        win_t r;
        r = (w == '0) ? win_t'(1) : w;
        if (int'(r) > WINDOW_MAX)
        begin
            r = win_t'(WINDOW_MAX);
        end
        return r;
    endfunction

    // ring full before this sample, and whether this sample gives a result
    assign status.full = (fill_reg >= win_reg);
    assign status.emit = status.full || (({1'b0, fill_reg} + 1'b1) == {1'b0, win_reg});

    // next slot, wrapping at the window
    always_comb
    begin
        if ((32'(pos_reg) + 32'd1) == 32'(win_reg))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // running sums: drop the oldest sample once full, add the new one
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            sum_next[i] = sum_reg[i] + sum_t'(sample_reg[i]);
            if (status.full)
            begin
                sum_next[i] = sum_next[i] - sum_t'(old_reg[i]);
            end
        end
    end

    // history control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_INIT;
            fill_reg <= '0;
            pos_reg  <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            win_reg  <= clamp_window(cfg_window);
            fill_reg <= '0;
            pos_reg  <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            pos_reg <= pos_next;
            if (!status.full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    // sample ring: oldest row read on accept, new row written on update
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        if (cmd.take)
        begin
            old_reg <= ring_mem[pos_reg];
        end
    end

    // restoring divide step, one quotient bit per cycle
    assign div_sum    = sum_reg[cmd.ch];
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, win_reg});
    assign trial_diff = trial - {1'b0, win_reg};
    assign quo_low    = quo_reg[DATA_W-1:0];

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= in_row;
            tag_reg    <= in_tag;
        end
        if (cmd.div_load)
        begin
            neg_reg <= div_sum[SUM_W-1];
            quo_reg <= div_sum[SUM_W-1] ? -div_sum : div_sum;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[CFG_W-1:0] : trial[CFG_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
        end
        if (cmd.div_store)
        begin
            stage_reg[cmd.ch] <= neg_reg ? -quo_low : quo_low;
        end
        if (cmd.out_load)
        begin
            mean_reg     <= stage_reg;
            mean_tag_reg <= tag_reg;
        end
    end

    assign mean_row = mean_reg;
    assign mean_tag = mean_tag_reg;

endmodule

### design/imu_moving_average.sv
// sequence: a sample that gives no result is taken in idle, added in update, and ready returns;
// otherwise each channel in turn is divided (load, steps, store), then the result beat is loaded
// one sample in flight: no new sample is taken before the result is loaded, and one shared
// restoring divider retires one quotient bit per cycle for each of ten channels
// reset: rst_n async active low; window of 10, history empty, output idle;
// ring contents undefined until written, no clearing pass
module imu_moving_average import imuma_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    imuma_sample_if.sink        sample_ch,
    imuma_mean_if.source        mean_ch,
    imuma_cfg_if.sink           window_ch
);

    localparam int SUM_W = DATA_W + $clog2(WINDOW_MAX);

    imuma_cmd_t    cmd;
    imuma_status_t status;
    row_t          in_row;
    row_t          mean_row;
    tag_t          mean_tag;

    // gather the input channels into one row
    always_comb
    begin
        in_row             = '0;
        in_row[CH_QUAT_X]  = sample_ch.quat_x;
        in_row[CH_QUAT_Y]  = sample_ch.quat_y;
        in_row[CH_QUAT_Z]  = sample_ch.quat_z;
        in_row[CH_QUAT_W]  = sample_ch.quat_w;
        in_row[CH_RATE_X]  = sample_ch.rate_x;
        in_row[CH_RATE_Y]  = sample_ch.rate_y;
        in_row[CH_RATE_Z]  = sample_ch.rate_z;
        in_row[CH_ACCEL_X] = sample_ch.accel_x;
        in_row[CH_ACCEL_Y] = sample_ch.accel_y;
        in_row[CH_ACCEL_Z] = sample_ch.accel_z;
    end

    imuma_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (mean_ch.valid),
        .out_ready (mean_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    imuma_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .SUM_W      (SUM_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_row     (in_row),
        .in_tag     (sample_ch.sample_tag),
        .cfg_valid  (window_ch.valid),
        .cfg_window (window_ch.avg_len),
        .mean_row   (mean_row),
        .mean_tag   (mean_tag)
    );

    // config writes are always taken
    assign window_ch.ready = 1'b1;

    // spread the result row onto the output beat
    assign mean_ch.mean_quat_x  = mean_row[CH_QUAT_X];
    assign mean_ch.mean_quat_y  = mean_row[CH_QUAT_Y];
    assign mean_ch.mean_quat_z  = mean_row[CH_QUAT_Z];
    assign mean_ch.mean_quat_w  = mean_row[CH_QUAT_W];
    assign mean_ch.mean_rate_x  = mean_row[CH_RATE_X];
    assign mean_ch.mean_rate_y  = mean_row[CH_RATE_Y];
    assign mean_ch.mean_rate_z  = mean_row[CH_RATE_Z];
    assign mean_ch.mean_accel_x = mean_row[CH_ACCEL_X];
    assign mean_ch.mean_accel_y = mean_row[CH_ACCEL_Y];
    assign mean_ch.mean_accel_z = mean_row[CH_ACCEL_Z];
    assign mean_ch.result_tag   = mean_tag;

endmodule

### design/imuma_checker.sv
module imuma_checker import imuma_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input data_t out_first,
    input tag_t  out_tag
);

    // one sample at a time: ready drops right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready stayed high after an accepted beat");

    // a result is handed off only from a busy cycle, never while waiting for input
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a sample in flight");

    // a stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_first) && $stable(out_tag)))
        else $error("result beat changed while stalled");

    // a result beat leaves only when taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result beat dropped without being taken");

endmodule

bind imu_moving_average imuma_checker u_imuma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (mean_ch.valid),
    .out_ready (mean_ch.ready),
    .out_first (mean_ch.mean_quat_x),
    .out_tag   (mean_ch.result_tag)
);
